// File: design/cspu_pkg.sv
// Shared types, register codes and bit-manipulation helpers for the CAN signal pack/unpack block.
// No dependencies; every other design file imports this package.
package cspu_pkg;

  localparam int unsigned PL_W      = 64;
  localparam int unsigned VAL_W     = 48;
  localparam int unsigned RAW_W     = 32;
  localparam int unsigned WIN_W     = 96;
  localparam int unsigned SH_W      = 7;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned PLEN_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 48;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_START_BIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_LENGTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_ORDER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IS_SIGNED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS          = 3'd6;

  // Operation and byte order codes
  localparam logic FUNC_DECODE    = 1'b0;
  localparam logic FUNC_ENCODE    = 1'b1;
  localparam logic ORDER_INTEL    = 1'b0;
  localparam logic ORDER_MOTOROLA = 1'b1;

  // Register reset values
  localparam logic [5:0]         RST_START_BIT     = 6'd0;
  localparam logic [5:0]         RST_BIT_LENGTH    = 6'd8;
  localparam logic               RST_BYTE_ORDER    = ORDER_INTEL;
  localparam logic               RST_IS_SIGNED     = 1'b0;
  localparam logic signed [31:0] RST_SCALE         = 32'sd65536;
  localparam logic signed [31:0] RST_INVERSE_SCALE = 32'sd65536;
  localparam logic signed [47:0] RST_BIAS          = 48'sd0;

  typedef struct packed {
    logic [5:0]         start_bit;
    logic [5:0]         bit_length;
    logic               byte_order;
    logic               is_signed;
    logic signed [31:0] scale;
    logic signed [31:0] inverse_scale;
    logic signed [47:0] bias;
  } cspu_cfg_t;

  // Field geometry derived from the configuration
  typedef struct packed {
    logic [LEN_W-1:0] n;      // effective length, 1..32
    logic [SH_W-1:0]  sh;     // field offset inside the 96-bit window
    logic [RAW_W-1:0] fmask;  // n low ones
  } cspu_geom_t;

  // Item after the align stages
  typedef struct packed {
    logic               func;
    logic [PL_W-1:0]    payload;
    logic [PLEN_W-1:0]  len;
    logic signed [32:0] sraw;
    logic [47:0]        ad;
    logic [31:0]        ai;
    logic               neg_sign;
  } cspu_align_t;

  // Item after the arithmetic stages
  typedef struct packed {
    logic                     func;
    logic [PL_W-1:0]          payload;
    logic [PLEN_W-1:0]        len;
    logic signed [VAL_W-1:0]  value;
    logic [RAW_W-1:0]         bits;
    logic                     flag;
  } cspu_arith_t;

  function automatic logic [PL_W-1:0] byte_swap(input logic [PL_W-1:0] v);
    logic [PL_W-1:0] r;
    for (int k = 0; k < 8; k++) begin
      r[8*k +: 8] = v[8*(7-k) +: 8];
    end
    return r;
  endfunction

  // Ones on bytes below min(len, max_bytes)
  function automatic logic [PL_W-1:0] valid_mask(input logic [PLEN_W-1:0] len,
                                                 input logic [PLEN_W-1:0] max_bytes);
    logic [PLEN_W-1:0] nb;
    logic [PL_W-1:0]   m;
    nb = (len < max_bytes) ? len : max_bytes;
    for (int k = 0; k < 8; k++) begin
      m[8*k +: 8] = (PLEN_W'(k) < nb) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // Intel fields sit at their start bit over 32 zero bits; Motorola fields are read
  // big-endian from the byte-swapped payload with 32 zero bits below it.
  function automatic logic [WIN_W-1:0] window(input logic [PL_W-1:0] pl, input logic order);
    logic [WIN_W-1:0] w;
    if (order == ORDER_MOTOROLA) begin
      w = {byte_swap(pl), 32'h0};
    end else begin
      w = {32'h0, pl};
    end
    return w;
  endfunction

  function automatic cspu_geom_t geometry(input cspu_cfg_t c);
    cspu_geom_t g;
    logic [5:0] s;
    if (c.bit_length == 6'd0) begin
      g.n = 6'd1;
    end else if (c.bit_length > 6'd32) begin
      g.n = 6'd32;
    end else begin
      g.n = c.bit_length;
    end
    s = c.start_bit ^ 6'd7;
    if (c.byte_order == ORDER_MOTOROLA) begin
      g.sh = SH_W'(7'd96 - {1'b0, s} - {1'b0, g.n});
    end else begin
      g.sh = {1'b0, c.start_bit};
    end
    g.fmask = 32'hFFFF_FFFF >> (6'd32 - g.n);
    return g;
  endfunction

  // Clamp a wide signed value to the 48-bit signed range
  function automatic logic signed [VAL_W-1:0] sat48(input logic signed [64:0] v);
    if (!v[64] && (v[63:47] != '0)) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v[64] && (v[63:47] != '1)) begin
      return 48'sh8000_0000_0000;
    end else begin
      return v[47:0];
    end
  endfunction

endpackage

// File: design/can_signal_pack_unpack.sv
// Top level of the CAN signal pack/unpack block: register file and six-stage pipeline.
// Depends on cspu_pkg, cspu_cfg, cspu_align, cspu_arith and cspu_insert.
//
// Usage:
//   Input channel in_*: one frame per transfer. in_func selects decode (read one
//   signal from in_payload_in) or encode (write in_value_in into the payload).
//   Result channel out_*: one result per input item, in order.
//   Config channel cfg_*: write register cfg_index with cfg_data; cfg_ready is
//   high whenever reset is released. Write registers only while no item is in flight.
// Throughput: one item per cycle while the result side is not stalled;
//   six register stages (window, extract, multiply, quotient/clamp,
//   bias/range, insert) each hold one item.
// Stall: while out_valid and out_stall are both high the whole pipeline holds
//   and in_stall is raised; nothing is dropped or repeated.
// Reset: synchronous, active low. Clears all valid bits and loads the
//   register defaults (start bit 0, length 8, Intel, unsigned, scale 1.0,
//   inverse scale 1.0, bias 0). in_stall is high and cfg_ready low during reset.
module can_signal_pack_unpack import cspu_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_func,
  input  logic [PL_W-1:0]         in_payload_in,
  input  logic [PLEN_W-1:0]       in_payload_len,
  input  logic signed [VAL_W-1:0] in_value_in,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [PL_W-1:0]         out_payload_out,
  output logic signed [VAL_W-1:0] out_value_out,
  output logic                    out_range_flag,
  // configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data
);

  cspu_cfg_t   cfg;
  cspu_geom_t  geom;
  logic        adv;
  logic        s2_valid;
  cspu_align_t s2;
  logic        s5_valid;
  cspu_arith_t s5;

  // Advance every stage unless a finished result is held by the receiver
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !rst_n || !adv;
  assign cfg_ready = rst_n;

  cspu_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .geom     (geom)
  );

  cspu_align #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_align (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_valid && !in_stall),
    .in_func    (in_func),
    .in_payload (in_payload_in),
    .in_len     (in_payload_len),
    .in_value   (in_value_in),
    .cfg        (cfg),
    .geom       (geom),
    .s2_valid   (s2_valid),
    .s2         (s2)
  );

  cspu_arith u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s2_valid (s2_valid),
    .s2       (s2),
    .cfg      (cfg),
    .geom     (geom),
    .s5_valid (s5_valid),
    .s5       (s5)
  );

  cspu_insert #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_insert (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .s5_valid    (s5_valid),
    .s5          (s5),
    .cfg         (cfg),
    .geom        (geom),
    .out_valid   (out_valid),
    .out_payload (out_payload_out),
    .out_value   (out_value_out),
    .out_flag    (out_range_flag)
  );

endmodule

// File: design/cspu_cfg.sv
// Configuration register file for the CAN signal pack/unpack block.
// Depends on cspu_pkg for register codes, reset values and geometry.
module cspu_cfg import cspu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_DAT_W-1:0] wr_data,
  output cspu_cfg_t            cfg,
  output cspu_geom_t           geom
);

  cspu_cfg_t cfg_r;

  // Take one register write per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_bit     <= RST_START_BIT;
      cfg_r.bit_length    <= RST_BIT_LENGTH;
      cfg_r.byte_order    <= RST_BYTE_ORDER;
      cfg_r.is_signed     <= RST_IS_SIGNED;
      cfg_r.scale         <= RST_SCALE;
      cfg_r.inverse_scale <= RST_INVERSE_SCALE;
      cfg_r.bias          <= RST_BIAS;
    end else if (wr_en) begin
      case (wr_index)
        REG_START_BIT:     cfg_r.start_bit     <= wr_data[5:0];
        REG_BIT_LENGTH:    cfg_r.bit_length    <= wr_data[5:0];
        REG_BYTE_ORDER:    cfg_r.byte_order    <= wr_data[0];
        REG_IS_SIGNED:     cfg_r.is_signed     <= wr_data[0];
        REG_SCALE:         cfg_r.scale         <= wr_data[31:0];
        REG_INVERSE_SCALE: cfg_r.inverse_scale <= wr_data[31:0];
        REG_BIAS:          cfg_r.bias          <= wr_data[47:0];
        default: ;
      endcase
    end
  end

  assign cfg  = cfg_r;
  assign geom = geometry(cfg_r);

endmodule

// File: design/cspu_align.sv
// Front stages: payload masking and windowing, field extraction, encode difference.
// Depends on cspu_pkg for types and helpers.
module cspu_align import cspu_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic                    in_func,
  input  logic [PL_W-1:0]         in_payload,
  input  logic [PLEN_W-1:0]       in_len,
  input  logic signed [VAL_W-1:0] in_value,
  input  cspu_cfg_t               cfg,
  input  cspu_geom_t              geom,
  output logic                    s2_valid,
  output cspu_align_t             s2
);

  localparam logic [PLEN_W-1:0] MAX_BYTES = PLEN_W'(PAYLOAD_BYTES);

  logic               s1_valid_r;
  logic               s1_func_r;
  logic [PL_W-1:0]    s1_payload_r;
  logic [PLEN_W-1:0]  s1_len_r;
  logic [WIN_W-1:0]   s1_win_r;
  logic [48:0]        s1_diff_r;
  logic [WIN_W-1:0]   win_nxt;
  logic [48:0]        diff_nxt;

  logic               s2_valid_r;
  cspu_align_t        s2_r;
  cspu_align_t        s2_nxt;
  logic [WIN_W-1:0]   shifted;
  logic [RAW_W-1:0]   raw;
  logic [48:0]        ad_full;

  // Stage 1: mask short payloads, build the window, form value minus bias
  assign win_nxt  = window(in_payload & valid_mask(in_len, MAX_BYTES), cfg.byte_order);
  assign diff_nxt = {in_value[VAL_W-1], in_value} - {cfg.bias[VAL_W-1], cfg.bias};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r    <= in_func;
      s1_payload_r <= in_payload;
      s1_len_r     <= in_len;
      s1_win_r     <= win_nxt;
      s1_diff_r    <= diff_nxt;
    end
  end

  // Stage 2: pull the field out, sign-extend, take magnitudes for the encode multiply
  assign shifted = s1_win_r >> geom.sh;
  assign raw     = shifted[RAW_W-1:0] & geom.fmask;
  assign ad_full = s1_diff_r[48] ? (~s1_diff_r + 49'd1) : s1_diff_r;

  always_comb begin
    s2_nxt.func    = s1_func_r;
    s2_nxt.payload = s1_payload_r;
    s2_nxt.len     = s1_len_r;
    if (cfg.is_signed && raw[5'(geom.n - 6'd1)]) begin
      s2_nxt.sraw = {1'b1, raw | ~geom.fmask};
    end else begin
      s2_nxt.sraw = {1'b0, raw};
    end
    s2_nxt.ad       = ad_full[47:0];
    s2_nxt.ai       = cfg.inverse_scale[31] ? (~cfg.inverse_scale + 32'd1)
                                            : cfg.inverse_scale;
    s2_nxt.neg_sign = s1_diff_r[48] ^ cfg.inverse_scale[31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2       = s2_r;

endmodule

// File: design/cspu_arith.sv
// Arithmetic stages: scale and bias for decode, inverse scaling and range clamp for encode.
// Depends on cspu_pkg for types and the 48-bit saturation helper.
module cspu_arith import cspu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        s2_valid,
  input  cspu_align_t s2,
  input  cspu_cfg_t   cfg,
  input  cspu_geom_t  geom,
  output logic        s5_valid,
  output cspu_arith_t s5
);

  // Stage 3 registers: products
  logic               s3_valid_r;
  logic               s3_func_r;
  logic [PL_W-1:0]    s3_payload_r;
  logic [PLEN_W-1:0]  s3_len_r;
  logic signed [64:0] s3_prod_r;
  logic [47:0]        s3_pp_hi_r;
  logic [63:0]        s3_pp_lo_r;
  logic               s3_neg_sign_r;
  logic signed [64:0] prod_nxt;

  // Stage 4 registers: saturated product, quotient
  logic                    s4_valid_r;
  logic                    s4_func_r;
  logic [PL_W-1:0]         s4_payload_r;
  logic [PLEN_W-1:0]       s4_len_r;
  logic signed [VAL_W-1:0] s4_prod_sat_r;
  logic [47:0]             s4_q_r;
  logic                    s4_neg_sign_r;

  // Stage 5
  logic                    s5_valid_r;
  cspu_arith_t             s5_r;
  cspu_arith_t             s5_nxt;
  logic signed [48:0]      sum;
  logic [RAW_W-1:0]        hi_lim;
  logic [RAW_W-1:0]        lo_mag;
  logic                    neg;

  // Stage 3: one signed multiply for decode, two partial products for encode
  assign prod_nxt = $signed({{33{cfg.scale[31]}}, cfg.scale}) *
                    $signed({{32{s2.sraw[32]}}, s2.sraw});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_func_r     <= s2.func;
      s3_payload_r  <= s2.payload;
      s3_len_r      <= s2.len;
      s3_prod_r     <= prod_nxt;
      s3_pp_hi_r    <= {32'h0, s2.ad[47:32]} * {16'h0, s2.ai};
      s3_pp_lo_r    <= {32'h0, s2.ad[31:0]} * {32'h0, s2.ai};
      s3_neg_sign_r <= s2.neg_sign;
    end
  end

  // Stage 4: clamp the decode product, combine partials into the truncated quotient
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_func_r     <= s3_func_r;
      s4_payload_r  <= s3_payload_r;
      s4_len_r      <= s3_len_r;
      s4_prod_sat_r <= sat48(s3_prod_r);
      s4_q_r        <= s3_pp_hi_r + {16'h0, s3_pp_lo_r[63:32]};
      s4_neg_sign_r <= s3_neg_sign_r;
    end
  end

  // Stage 5: add bias for decode, clamp raw to the field range for encode
  assign sum    = $signed({s4_prod_sat_r[VAL_W-1], s4_prod_sat_r}) +
                  $signed({cfg.bias[VAL_W-1], cfg.bias});
  assign hi_lim = cfg.is_signed ? {1'b0, geom.fmask[RAW_W-1:1]} : geom.fmask;
  assign lo_mag = cfg.is_signed ? ({1'b0, geom.fmask[RAW_W-1:1]} + 32'd1) : 32'd0;
  assign neg    = s4_neg_sign_r && (s4_q_r != 48'd0);

  always_comb begin
    s5_nxt.func    = s4_func_r;
    s5_nxt.payload = s4_payload_r;
    s5_nxt.len     = s4_len_r;
    s5_nxt.value   = sat48({{16{sum[48]}}, sum});
    s5_nxt.flag    = 1'b0;
    if (neg) begin
      if (s4_q_r > {16'h0, lo_mag}) begin
        s5_nxt.bits = lo_mag;
        s5_nxt.flag = 1'b1;
      end else begin
        s5_nxt.bits = (~s4_q_r[RAW_W-1:0] + 32'd1) & geom.fmask;
      end
    end else if (s4_q_r > {16'h0, hi_lim}) begin
      s5_nxt.bits = hi_lim;
      s5_nxt.flag = 1'b1;
    end else begin
      s5_nxt.bits = s4_q_r[RAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_r <= s5_nxt;
    end
  end

  assign s5_valid = s5_valid_r;
  assign s5       = s5_r;

endmodule

// File: design/cspu_insert.sv
// Final stage: inserts the encoded field into the payload and holds the result register.
// Depends on cspu_pkg for types and window helpers.
module cspu_insert import cspu_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    s5_valid,
  input  cspu_arith_t             s5,
  input  cspu_cfg_t               cfg,
  input  cspu_geom_t              geom,
  output logic                    out_valid,
  output logic [PL_W-1:0]         out_payload,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_flag
);

  localparam logic [PLEN_W-1:0] MAX_BYTES = PLEN_W'(PAYLOAD_BYTES);

  logic [PL_W-1:0]         vm;
  logic [WIN_W-1:0]        win;
  logic [WIN_W-1:0]        fmask_w;
  logic [WIN_W-1:0]        bits_w;
  logic [WIN_W-1:0]        win_out;
  logic [PL_W-1:0]         enc_payload;
  logic                    valid_r;
  logic [PL_W-1:0]         payload_r;
  logic signed [VAL_W-1:0] value_r;
  logic                    flag_r;

  // Replace the field bits inside the window, then map back to payload order
  assign vm      = valid_mask(s5.len, MAX_BYTES);
  assign win     = window(s5.payload & vm, cfg.byte_order);
  assign fmask_w = {64'h0, geom.fmask} << geom.sh;
  assign bits_w  = {64'h0, s5.bits} << geom.sh;
  assign win_out = (win & ~fmask_w) | (bits_w & fmask_w);

  always_comb begin
    if (cfg.byte_order == ORDER_MOTOROLA) begin
      enc_payload = byte_swap(win_out[WIN_W-1:32]) & vm;
    end else begin
      enc_payload = win_out[PL_W-1:0] & vm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= s5_valid;
    end
  end

  // Decode echoes the payload and reports no flag; encode reports a zero value
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s5.func == FUNC_ENCODE) begin
        payload_r <= enc_payload;
        value_r   <= '0;
        flag_r    <= s5.flag;
      end else begin
        payload_r <= s5.payload;
        value_r   <= s5.value;
        flag_r    <= 1'b0;
      end
    end
  end

  assign out_valid   = valid_r;
  assign out_payload = payload_r;
  assign out_value   = value_r;
  assign out_flag    = flag_r;

endmodule

// File: design/cspu_checker.sv
// Port-level checks for the CAN signal pack/unpack block, bound to the top level.
// Depends on cspu_pkg for field widths.
module cspu_checker import cspu_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [PL_W-1:0]         out_payload_out,
  input logic signed [VAL_W-1:0] out_value_out,
  input logic                    out_range_flag
);

  // Held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_out) &&
                               $stable(out_value_out) && $stable(out_range_flag))
    else $error("result changed while stalled");

  // Input back-pressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A flagged result is an encode, which reports a zero value
  a_flag_encode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_flag |-> out_value_out == '0)
    else $error("range flag on a decode result");

  // With the output free, an accepted item shows up as a valid result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind can_signal_pack_unpack cspu_checker u_cspu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_payload_out (out_payload_out),
  .out_value_out   (out_value_out),
  .out_range_flag  (out_range_flag)
);

// File: dv/can_signal_pack_unpack_tb.sv
// Self-checking testbench for can_signal_pack_unpack: a directed script, then random phases.
// Each accepted frame is predicted from a shadow copy of the registers. Depends on cspu_pkg.
`timescale 1ns / 100ps

module can_signal_pack_unpack_tb;
  import cspu_pkg::*;

  typedef longint unsigned u64_t;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned PHASES          = 14;
  localparam int unsigned ITEMS_PER_PHASE = 102;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam longint      Q48_MAX         = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      Q48_MIN         = -Q48_MAX - 1;

  typedef struct packed {
    logic [PL_W-1:0]         payload;
    logic signed [VAL_W-1:0] value;
    logic                    flag;
  } frame_result_t;

  // One step of the directed script: a register write or a frame
  typedef struct {
    bit                   reg_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_data;
    logic                 func;
    logic [PL_W-1:0]      payload;
    logic [PLEN_W-1:0]    len;
    logic [VAL_W-1:0]     value;
    bit                   known;
    frame_result_t        want;
  } script_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_func = FUNC_DECODE;
  logic [PL_W-1:0]         in_payload_in = '0;
  logic [PLEN_W-1:0]       in_payload_len = '0;
  logic signed [VAL_W-1:0] in_value_in = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [PL_W-1:0]         out_payload_out;
  logic signed [VAL_W-1:0] out_value_out;
  logic                    out_range_flag;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DAT_W-1:0]    cfg_data = '0;

  cspu_cfg_t shadow_cfg = '{start_bit: RST_START_BIT, bit_length: RST_BIT_LENGTH,
                            byte_order: RST_BYTE_ORDER, is_signed: RST_IS_SIGNED,
                            scale: RST_SCALE, inverse_scale: RST_INVERSE_SCALE,
                            bias: RST_BIAS};

  frame_result_t expected_frames[$];
  script_row_t   script[$];
  int unsigned   errors = 0;
  int unsigned   results_seen = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   gap_tick = 0;
  int unsigned   stall_tick = 0;
  int unsigned   stall_left = 0;
  bit            in_calm = 1'b0;
  bit            out_calm = 1'b0;

  can_signal_pack_unpack DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_payload_in   (in_payload_in),
    .in_payload_len  (in_payload_len),
    .in_value_in     (in_value_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_payload_out (out_payload_out),
    .out_value_out   (out_value_out),
    .out_range_flag  (out_range_flag),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // Clamp the length register to 1..32
  function automatic int unsigned field_len(cspu_cfg_t c);
    if (c.bit_length == 6'd0) return 1;
    if (c.bit_length > 6'd32) return 32;
    return 32'(c.bit_length);
  endfunction

  function automatic longint clamp_q48(longint v);
    if (v > Q48_MAX) return Q48_MAX;
    if (v < Q48_MIN) return Q48_MIN;
    return v;
  endfunction

  // Payload bit carrying the i-th signal bit in transmit order, 64 when off the end
  function automatic int unsigned signal_bit_pos(cspu_cfg_t c, int unsigned i);
    int unsigned s;
    int unsigned p;
    s = 32'(c.start_bit);
    if (c.byte_order == ORDER_MOTOROLA) s = s ^ 7;
    p = s + i;
    if (p >= 64) return 64;
    return (c.byte_order == ORDER_MOTOROLA) ? (p ^ 7) : p;
  endfunction

  function automatic frame_result_t predict_frame(cspu_cfg_t c, logic f, logic [PL_W-1:0] pl,
                                                  logic [PLEN_W-1:0] len,
                                                  logic signed [VAL_W-1:0] val);
    frame_result_t r;
    logic [PL_W-1:0] vm;
    logic [PL_W-1:0] pl_m;
    int unsigned n;
    int unsigned nb;
    int unsigned p;
    int unsigned ri;
    u64_t raw;
    u64_t ad;
    u64_t ai;
    u64_t a;
    u64_t b;
    u64_t q;
    u64_t bits;
    longint sc;
    longint inv;
    longint bs;
    longint vv;
    longint sraw;
    longint d;
    longint hi;
    longint lo;
    longint rv;
    bit neg;
    n  = field_len(c);
    nb = (len < 4'd8) ? 32'(len) : 8;
    vm = (nb >= 8) ? '1 : ((64'd1 << (8 * nb)) - 64'd1);
    pl_m = pl & vm;
    sc  = longint'(c.scale);
    inv = longint'(c.inverse_scale);
    bs  = longint'(c.bias);
    vv  = longint'(val);
    r = '0;
    if (f == FUNC_DECODE) begin
      // gather the field, then scale and offset with saturation
      raw = 0;
      for (int unsigned i = 0; i < n; i++) begin
        p  = signal_bit_pos(c, i);
        ri = (c.byte_order == ORDER_MOTOROLA) ? (n - 1 - i) : i;
        if (p < 64 && pl_m[p]) raw = raw | (64'd1 << ri);
      end
      if (c.is_signed && raw[n-1]) sraw = longint'(raw) - longint'(64'd1 << n);
      else sraw = longint'(raw);
      r.payload = pl;
      r.value   = 48'(clamp_q48(clamp_q48(sc * sraw) + bs));
    end else begin
      // magnitude product, truncated toward zero, then clamp to the field range
      d  = vv - bs;
      ad = (d < 0) ? u64_t'(-d) : u64_t'(d);
      ai = (inv < 0) ? u64_t'(-inv) : u64_t'(inv);
      a  = (ad >> 16) * ai;
      b  = (ad & 64'hFFFF) * ai;
      q  = (a >> 16) + ((((a & 64'hFFFF) << 16) + b) >> 32);
      neg = ((d < 0) != (inv < 0)) && (q != 0);
      if (c.is_signed) begin
        hi = longint'((64'd1 << (n - 1)) - 64'd1);
        lo = -hi - 1;
      end else begin
        hi = longint'((64'd1 << n) - 64'd1);
        lo = 0;
      end
      if (neg) begin
        if (q > u64_t'(-lo)) begin
          rv = lo;
          r.flag = 1'b1;
        end else begin
          rv = -longint'(q);
        end
      end else if (q > u64_t'(hi)) begin
        rv = hi;
        r.flag = 1'b1;
      end else begin
        rv = longint'(q);
      end
      bits = u64_t'(rv) & ((64'd1 << n) - 64'd1);
      for (int unsigned i = 0; i < n; i++) begin
        p  = signal_bit_pos(c, i);
        ri = (c.byte_order == ORDER_MOTOROLA) ? (n - 1 - i) : i;
        if (p < 64) pl_m[p] = bits[ri];
      end
      r.payload = pl_m & vm;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- directed script

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    script_row_t row;
    row = '{default: '0};
    row.reg_write = 1'b1;
    row.reg_idx   = idx;
    row.reg_data  = data;
    script.push_back(row);
  endfunction

  function automatic void add_frame(logic f, logic [PL_W-1:0] pl, logic [PLEN_W-1:0] len,
                                    logic [VAL_W-1:0] val);
    script_row_t row;
    row = '{default: '0};
    row.func    = f;
    row.payload = pl;
    row.len     = len;
    row.value   = val;
    script.push_back(row);
  endfunction

  function automatic void add_known(logic f, logic [PL_W-1:0] pl, logic [PLEN_W-1:0] len,
                                    logic [VAL_W-1:0] val, logic [PL_W-1:0] w_pl,
                                    logic [VAL_W-1:0] w_val, logic w_flag);
    add_frame(f, pl, len, val);
    script[$].known = 1'b1;
    script[$].want  = '{payload: w_pl, value: w_val, flag: w_flag};
  endfunction

  // ---------------------------------------------------------------- driving

  // Mostly back-to-back, some short gaps, a few long ones, and calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    gap_tick++;
    if (gap_tick % 128 == 0) in_calm = ($urandom_range(0, 3) == 0);
    if (in_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Present one frame and hold it until the transfer, then queue its expected result
  task automatic push_frame(logic f, logic [PL_W-1:0] pl, logic [PLEN_W-1:0] len,
                            logic [VAL_W-1:0] val, bit known, frame_result_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_payload_in  <= pl;
    in_payload_len <= len;
    in_value_in    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_frames.push_back(known ? want : predict_frame(shadow_cfg, f, pl, len, val));
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic settle_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_START_BIT:     shadow_cfg.start_bit     = data[5:0];
      REG_BIT_LENGTH:    shadow_cfg.bit_length    = data[5:0];
      REG_BYTE_ORDER:    shadow_cfg.byte_order    = data[0];
      REG_IS_SIGNED:     shadow_cfg.is_signed     = data[0];
      REG_SCALE:         shadow_cfg.scale         = data[31:0];
      REG_INVERSE_SCALE: shadow_cfg.inverse_scale = data[31:0];
      REG_BIAS:          shadow_cfg.bias          = data[47:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Random backpressure on the result side, with calm stretches
  always @(posedge clk) begin : drive_out_stall
    int unsigned r;
    stall_tick++;
    if (stall_tick % 200 == 0) out_calm = ($urandom_range(0, 3) == 0);
    if (stall_left != 0) begin
      stall_left--;
    end else if (!out_calm) begin
      r = $urandom_range(0, 99);
      if (r >= 92) stall_left = $urandom_range(5, 20);
      else if (r >= 70) stall_left = $urandom_range(1, 3);
    end
    out_stall <= (stall_left != 0);
  end

  // ---------------------------------------------------------------- checking

  task automatic flag_error(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= REPORT_LIMIT)
      $display("%0t ns result %0d: %s: expected %h, got %h", $time, results_seen, what,
               want, got);
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        flag_error("result with nothing pending", '0, out_payload_out);
      end else begin
        want = expected_frames.pop_front();
        if (out_payload_out !== want.payload)
          flag_error("payload_out", want.payload, out_payload_out);
        if (out_value_out !== want.value)
          flag_error("value_out", 64'($unsigned(want.value)), 64'($unsigned(out_value_out)));
        if (out_range_flag !== want.flag)
          flag_error("range_flag", 64'(want.flag), 64'(out_range_flag));
      end
    end
  end

  // End the run when no channel has moved for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    frame_result_t    none;
    logic [5:0]       sb;
    logic [5:0]       bl;
    logic [31:0]      sc;
    logic [31:0]      iv;
    logic [VAL_W-1:0] bias_w;
    logic [PL_W-1:0]  pl;
    logic [PLEN_W-1:0] plen;
    logic             fn;
    longint           hi;
    longint           lo;
    longint           t;
    longint           v;
    longint           bs;
    u64_t             rnd;
    int unsigned      n;
    int unsigned      r;
    int unsigned      k;
    none = '0;

    // Reset defaults: start 0, 8 bits, Intel, unsigned, unity scale, no bias
    add_known(FUNC_DECODE, 64'h0123_4567_89AB_CDEF, 4'd8, '0,
              64'h0123_4567_89AB_CDEF, 48'h0000_00EF_0000, 1'b0);
    add_known(FUNC_DECODE, '1, 4'd0, '0, '1, '0, 1'b0);
    add_known(FUNC_ENCODE, '0, 4'd8, 48'h0000_0012_0000, 64'h12, '0, 1'b0);
    add_known(FUNC_ENCODE, '0, 4'd8, 48'h0000_0100_0000, 64'hFF, '0, 1'b1);
    add_known(FUNC_ENCODE, '1, 4'd8, 48'hFFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_FF00, '0, 1'b1);
    add_known(FUNC_ENCODE, '0, 4'd3, 48'h7FFF_FFFF_FFFF, 64'hFF, '0, 1'b1);
    add_known(FUNC_ENCODE, '1, 4'd15, 48'h8000_0000_0000, 64'hFFFF_FFFF_FFFF_FF00, '0, 1'b1);
    add_known(FUNC_ENCODE, '1, 4'd0, 48'h0000_0005_0000, '0, '0, 1'b0);
    // Intel field running off the top of the payload
    add_reg(REG_START_BIT, 48'd60);
    add_known(FUNC_DECODE, '1, 4'd8, '0, '1, 48'h0000_000F_0000, 1'b0);
    add_known(FUNC_ENCODE, '0, 4'd8, 48'h0000_00FF_0000, 64'hF000_0000_0000_0000, '0, 1'b0);
    // Motorola 16-bit field over bytes 0 and 1
    add_reg(REG_BYTE_ORDER, 48'(ORDER_MOTOROLA));
    add_reg(REG_START_BIT, 48'd7);
    add_reg(REG_BIT_LENGTH, 48'd16);
    add_known(FUNC_DECODE, 64'h0123_4567_89AB_CDEF, 4'd8, '0,
              64'h0123_4567_89AB_CDEF, 48'h0000_EFCD_0000, 1'b0);
    add_known(FUNC_ENCODE, '0, 4'd8, 48'h0000_1234_0000, 64'h3412, '0, 1'b0);
    // Motorola 32-bit field starting in the last byte, unsigned then signed
    add_reg(REG_START_BIT, 48'd63);
    add_reg(REG_BIT_LENGTH, 48'd32);
    add_known(FUNC_DECODE, 64'hA500_0000_0000_0000, 4'd8, '0,
              64'hA500_0000_0000_0000, 48'h7FFF_FFFF_FFFF, 1'b0);
    add_reg(REG_IS_SIGNED, 48'd1);
    add_known(FUNC_DECODE, 64'hA500_0000_0000_0000, 4'd8, '0,
              64'hA500_0000_0000_0000, 48'hA500_0000_0000, 1'b0);
    add_frame(FUNC_ENCODE, 64'h0123_4567_89AB_CDEF, 4'd8, 48'hFFFF_FFFE_0000);
    // Zero length acts as a single signed bit
    add_reg(REG_BYTE_ORDER, 48'(ORDER_INTEL));
    add_reg(REG_START_BIT, 48'd0);
    add_reg(REG_BIT_LENGTH, 48'd0);
    add_known(FUNC_DECODE, 64'h1, 4'd8, '0, 64'h1, 48'hFFFF_FFFF_0000, 1'b0);
    add_known(FUNC_ENCODE, '1, 4'd8, 48'h0000_0001_0000, 64'hFFFF_FFFF_FFFF_FFFE, '0, 1'b1);
    // Over-long length with extreme scale and bias saturates the decoded value
    add_reg(REG_BIT_LENGTH, 48'd33);
    add_reg(REG_IS_SIGNED, 48'd0);
    add_reg(REG_SCALE, 48'h0000_7FFF_FFFF);
    add_reg(REG_BIAS, 48'h7FFF_FFFF_FFFF);
    add_known(FUNC_DECODE, '1, 4'd8, '0, '1, 48'h7FFF_FFFF_FFFF, 1'b0);
    add_reg(REG_SCALE, 48'h0000_8000_0000);
    add_reg(REG_BIAS, 48'h8000_0000_0000);
    add_known(FUNC_DECODE, '1, 4'd8, '0, '1, 48'h8000_0000_0000, 1'b0);
    // Extreme and zero inverse scale on encode
    add_reg(REG_INVERSE_SCALE, 48'h0000_8000_0000);
    add_reg(REG_BIAS, 48'd0);
    add_frame(FUNC_ENCODE, '0, 4'd8, 48'h0000_0001_0000);
    add_reg(REG_INVERSE_SCALE, 48'd0);
    add_frame(FUNC_ENCODE, '0, 4'd8, 48'h7FFF_FFFF_FFFF);
    add_reg(REG_IS_SIGNED, 48'd1);
    add_reg(REG_INVERSE_SCALE, 48'h0000_7FFF_FFFF);
    add_frame(FUNC_ENCODE, '0, 4'd8, 48'h7FFF_FFFF_FFFF);
    add_frame(FUNC_ENCODE, '1, 4'd8, 48'h8000_0000_0000);
    add_frame(FUNC_DECODE, 64'hFEDC_BA98_7654_3210, 4'd4, '0);

    // Hold reset, then release
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].reg_write) begin
        settle_pipe();
        write_reg(script[i].reg_idx, script[i].reg_data);
      end else begin
        push_frame(script[i].func, script[i].payload, script[i].len, script[i].value,
                   script[i].known, script[i].want);
      end
    end

    // Random phases, each with a fresh register setting
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      settle_pipe();
      if ($urandom_range(0, 6) == 0) sb = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      else sb = 6'($urandom_range(0, 63));
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 4))
          0: bl = 6'd0;
          1: bl = 6'd1;
          2: bl = 6'd32;
          3: bl = 6'd33;
          default: bl = 6'd63;
        endcase
      end else begin
        bl = 6'($urandom_range(1, 32));
      end
      r = $urandom_range(0, 9);
      if (r < 4) begin
        sc = 32'd65536;
        iv = 32'd65536;
      end else if (r < 7) begin
        k = $urandom_range(0, 8);
        if ($urandom_range(0, 1)) begin
          sc = 32'd65536 << k;
          iv = 32'd65536 >> k;
        end else begin
          sc = 32'd65536 >> k;
          iv = 32'd65536 << k;
        end
        if ($urandom_range(0, 1)) begin
          sc = -sc;
          iv = -iv;
        end
      end else if (r == 7) begin
        case ($urandom_range(0, 3))
          0: sc = 32'h0;
          1: sc = 32'h7FFF_FFFF;
          2: sc = 32'h8000_0000;
          default: sc = 32'hFFFF_FFFF;
        endcase
        case ($urandom_range(0, 3))
          0: iv = 32'h0;
          1: iv = 32'h7FFF_FFFF;
          2: iv = 32'h8000_0000;
          default: iv = 32'h1;
        endcase
      end else begin
        sc = $urandom;
        iv = $urandom;
      end
      r = $urandom_range(0, 9);
      if (r < 5) bias_w = '0;
      else if (r < 8) bias_w = 48'(longint'($urandom_range(0, 33554432)) - 64'sd16777216);
      else if (r == 8) bias_w = $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
      else bias_w = 48'({$urandom, $urandom});
      write_reg(REG_START_BIT, 48'(sb));
      write_reg(REG_BIT_LENGTH, 48'(bl));
      write_reg(REG_BYTE_ORDER, 48'($urandom_range(0, 1)));
      write_reg(REG_IS_SIGNED, 48'($urandom_range(0, 1)));
      write_reg(REG_SCALE, 48'(sc));
      write_reg(REG_INVERSE_SCALE, 48'(iv));
      write_reg(REG_BIAS, bias_w);

      n  = field_len(shadow_cfg);
      bs = longint'(shadow_cfg.bias);
      if (shadow_cfg.is_signed) begin
        hi = longint'((64'd1 << (n - 1)) - 64'd1);
        lo = -hi - 1;
      end else begin
        hi = longint'((64'd1 << n) - 64'd1);
        lo = 0;
      end

      for (int unsigned it = 0; it < ITEMS_PER_PHASE; it++) begin
        fn = $urandom_range(0, 1) ? FUNC_ENCODE : FUNC_DECODE;
        plen = ($urandom_range(0, 3) != 0) ? 4'd8 : 4'($urandom_range(0, 15));
        r = $urandom_range(0, 19);
        if (r == 0) pl = '0;
        else if (r == 1) pl = '1;
        else if (r == 2) pl = 64'd1 << $urandom_range(0, 63);
        else pl = {$urandom, $urandom};
        // Encode values aimed at the field limits, near the bias, or anywhere
        r = $urandom_range(0, 99);
        if (fn == FUNC_ENCODE && r < 40) begin
          case ($urandom_range(0, 7))
            0: t = hi;
            1: t = hi + 1;
            2: t = lo;
            3: t = lo - 1;
            4: t = 0;
            5: t = -1;
            default: begin
              rnd = {$urandom, $urandom};
              t = lo + longint'(rnd % u64_t'(hi - lo + 1));
            end
          endcase
          v = bs + t * 65536 + longint'($urandom_range(0, 65535));
        end else if (fn == FUNC_ENCODE && r < 70) begin
          v = bs + longint'($urandom_range(0, 33554432)) - 64'sd16777216;
        end else begin
          v = {$urandom, $urandom};
        end
        push_frame(fn, pl, plen, v[47:0], 1'b0, none);
      end
    end

    settle_pipe();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
design/cspu_pkg.sv
design/cspu_cfg.sv
design/cspu_align.sv
design/cspu_arith.sv
design/cspu_insert.sv
design/can_signal_pack_unpack.sv
design/cspu_checker.sv
dv/can_signal_pack_unpack_tb.sv
